// ----- rtl/modular_exponentiation_macros.svh -----
// assertion macros used by the modular exponentiation controller
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MXP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mxp_pkg.sv -----
`timescale 1ns / 1ps

package mxp_pkg;

	// default operand width
	localparam int WIDTH_DEFAULT = 32;

	// field and bus widths
	localparam int FIELD_W = 32;
	localparam int ADDR_W  = 3;

	// register index of the modulus
	localparam logic REG_MODULUS = 1'b0;

	// reset value of the modulus
	localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd1;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new word, start base reduction
		logic step;   // one shift-subtract step on both reducers
		logic bset;   // take the reduced base
		logic mul;    // form both products, load the reducers
		logic upd;    // write back, shift the exponent
		logic fin;    // capture the result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic e_zero; // exponent exhausted
		logic e_last; // no exponent bit set above the current one
	} status_t;

endpackage

// ----- rtl/mxp_dpath.sv -----
`timescale 1ns / 1ps

module mxp_dpath #(
	parameter int WIDTH = mxp_pkg::WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  mxp_pkg::cmd_t        cmd,
	input  logic [WIDTH-1:0]     modulus,
	input  logic [WIDTH-1:0]     base,
	input  logic [WIDTH-1:0]     exponent,
	output mxp_pkg::status_t     status,
	output logic [WIDTH-1:0]     power
);

	// one restoring step: shift in a bit, subtract the modulus if it fits
	function automatic logic [WIDTH:0] red_step(
		input logic [WIDTH:0] rem,
		input logic           din,
		input logic [WIDTH:0] m
	);
		logic [WIDTH+1:0] trial;
		trial = {rem, din};
		if (trial >= {1'b0, m}) begin
			trial = trial - {1'b0, m};
		end
		return trial[WIDTH:0];
	endfunction

	logic [WIDTH:0]       mod_ext;
	logic [WIDTH-1:0]     acc_q;
	logic [WIDTH-1:0]     b_q;
	logic [WIDTH-1:0]     e_q;
	logic [WIDTH:0]       rema_q;
	logic [WIDTH:0]       remb_q;
	logic [WIDTH-1:0]     lowa_q;
	logic [WIDTH-1:0]     lowb_q;
	logic [WIDTH-1:0]     power_q;
	logic [2*WIDTH-1:0]   prod_a;
	logic [2*WIDTH-1:0]   prod_b;

	// a zero modulus acts as 2^WIDTH: reductions keep the low bits
	assign mod_ext = (modulus == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, modulus};

	// multiply by the running result and square the base
	assign prod_a = acc_q * b_q;
	assign prod_b = b_q * b_q;

	// operand registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= {{(WIDTH-1){1'b0}}, 1'b1};
			e_q   <= exponent;
		end
		if (cmd.bset) begin
			b_q <= remb_q[WIDTH-1:0];
		end
		if (cmd.upd) begin
			if (e_q[0]) begin
				acc_q <= rema_q[WIDTH-1:0];
			end
			b_q <= remb_q[WIDTH-1:0];
			e_q <= e_q >> 1;
		end
	end

	// two shift-subtract reducers; the high half of a product of reduced
	// operands is already below the modulus
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			remb_q <= '0;
			lowb_q <= base;
		end else if (cmd.mul) begin
			rema_q <= {1'b0, prod_a[2*WIDTH-1:WIDTH]};
			lowa_q <= prod_a[WIDTH-1:0];
			remb_q <= {1'b0, prod_b[2*WIDTH-1:WIDTH]};
			lowb_q <= prod_b[WIDTH-1:0];
		end else if (cmd.step) begin
			rema_q <= red_step(rema_q, lowa_q[WIDTH-1], mod_ext);
			lowa_q <= lowa_q << 1;
			remb_q <= red_step(remb_q, lowb_q[WIDTH-1], mod_ext);
			lowb_q <= lowb_q << 1;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			power_q <= acc_q;
		end
	end

	assign status.e_zero = (e_q == '0);
	assign status.e_last = (e_q[WIDTH-1:1] == '0);
	assign power         = power_q;

endmodule

// ----- rtl/mxp_ctrl.sv -----
`timescale 1ns / 1ps

`include "modular_exponentiation_macros.svh"

module mxp_ctrl #(
	parameter int WIDTH = mxp_pkg::WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  mxp_pkg::status_t status,
	output mxp_pkg::cmd_t    cmd
);

	localparam int CW = $clog2(WIDTH);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_BRED  = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_RED   = 7'b0010000,
		ST_UPD   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t         state_q;
	state_t         state_d;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_d;
	logic           rsp_valid_q;
	logic           slot_free;

	// the result slot frees when empty or taken this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CW'(WIDTH - 1);
					state_d  = ST_BRED;
				end
			end
			ST_BRED: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_CHECK;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.bset = 1'b1;
				state_d  = status.e_zero ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = CW'(WIDTH - 1);
				state_d = ST_RED;
			end
			ST_RED: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_UPD;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = status.e_last ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// a result only appears out of the finish state
	`MXP_ASSERT_SAME(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q == ST_FIN), "result without finish")
	// an accepted word starts the base reduction
	`MXP_ASSERT_NEXT(a_load_bred, req_valid && !req_stall, state_q == ST_BRED, "load did not reduce base")
	// a reduction runs until its counter is spent
	`MXP_ASSERT_NEXT(a_red_hold, state_q == ST_RED && cnt_q != '0, state_q == ST_RED, "reduction cut short")
	// finish never overwrites a stalled result
	`MXP_ASSERT_SAME(a_no_overwrite, cmd.fin, !rsp_valid_q || !rsp_stall, "result overwritten")

endmodule

// ----- rtl/modular_exponentiation.sv -----
// sequence: accept, base reduction, then a multiply, reduction and update per exponent
// bit up to the highest set bit, then the finish state loads the result and sets rsp_valid
// one word at a time: req_stall holds off new words until the controller is back in
// idle after the finish state; the time per word is set by the WIDTH-step reducers
// a new word is accepted while the previous result still waits on rsp_stall
// reset: asynchronous active-low arst_n idles the controller, clears rsp_valid, modulus 1
`timescale 1ns / 1ps

module modular_exponentiation #(
	parameter int WIDTH = mxp_pkg::WIDTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [mxp_pkg::FIELD_W-1:0]  base,
	input  logic [mxp_pkg::FIELD_W-1:0]  exponent,
	// response channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [mxp_pkg::FIELD_W-1:0]  power,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mxp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mxp_pkg::FIELD_W-1:0]  pwdata,
	output logic [mxp_pkg::FIELD_W-1:0]  prdata,
	output logic                         pready
);

	logic [mxp_pkg::FIELD_W-1:0] modulus_q;
	logic                        reg_sel;
	mxp_pkg::cmd_t               cmd;
	mxp_pkg::status_t            status;
	logic [WIDTH-1:0]            power_w;

	// register decode, word index in the top address bit
	assign reg_sel = (paddr[mxp_pkg::ADDR_W-1] == mxp_pkg::REG_MODULUS);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? modulus_q : '0;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mxp_pkg::MODULUS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			modulus_q <= pwdata;
		end
	end

	mxp_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mxp_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.modulus  (modulus_q[WIDTH-1:0]),
		.base     (base[WIDTH-1:0]),
		.exponent (exponent[WIDTH-1:0]),
		.status   (status),
		.power    (power_w)
	);

	assign power = mxp_pkg::FIELD_W'(power_w);

endmodule
